// ----- design/sct_pkg.sv -----
// Shared types and constants of the sine, cosine and tangent pipeline.
// Depends on nothing; every other design file but sct_if imports it.
package sct_pkg;

  // Internal values are signed counts of 2^-32.
  localparam int QW = 40;
  localparam int MW = QW - 1;
  typedef logic signed [QW-1:0] q_t;

  localparam int FRAC = 32;

  localparam q_t Q_PI      = 40'sd13493037705;
  localparam q_t Q_TWO_PI  = 40'sd26986075409;
  localparam q_t Q_HALF_PI = 40'sd6746518852;
  localparam q_t Q_TAN_EPS = 40'sd429497;

  typedef enum logic [1:0] {
    ACT_SIN = 2'd0,
    ACT_COS = 2'd1,
    ACT_TAN = 2'd2
  } act_t;

  // Division by a term constant through a reciprocal.
  localparam int DIV_SHIFT = 38;
  localparam int RECW      = 36;
  localparam int KW        = 7;

  localparam int NTERM    = 4;
  localparam int LANE_LAT = 2 + NTERM * 6;

  // Tangent quotient divider.
  localparam int DM   = 33;
  localparam int QB   = 47;
  localparam int SPS  = 4;
  localparam int NSTG = (QB + SPS - 1) / SPS;
  localparam int DIV_LAT = NSTG + 1;

  localparam int TOTAL_LAT = 3 + LANE_LAT + 1 + DIV_LAT + 1;

  typedef struct packed {
    logic [1:0] act;
    logic       cos_tiny;
    logic       neg;
    q_t         pass;
  } side_t;

  function automatic int unsigned term_div(int j);
    case (j)
      0:       return 6;
      1:       return 20;
      2:       return 42;
      default: return 72;
    endcase
  endfunction

endpackage

// ----- design/sct_if.sv -----
// Request channels of the sine, cosine and tangent block.
// Depends on nothing; the top level uses both interfaces.
interface sct_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic signed [31:0] angle;

  modport source (output valid, output action, output angle, input ready);
  modport sink (input valid, input action, input angle, output ready);
endinterface

interface sct_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] value;
  logic               small_cosine;

  modport source (output valid, output value, output small_cosine, input ready);
  modport sink (input valid, input value, input small_cosine, output ready);
endinterface

// ----- design/sct_qmul.sv -----
// Two-stage signed Q32 multiplier with round to nearest, ties away from zero.
// Depends on sct_pkg.
module sct_qmul import sct_pkg::*; (
  input  logic clk,
  input  logic en,
  input  q_t   a_i,
  input  q_t   b_i,
  output q_t   p_o
);
  localparam int HW = MW - 32;

  logic [MW-1:0]   ma, mb;
  logic [63:0]     ll_r;
  logic [MW-1:0]   lh_r, hl_r;
  logic [2*HW-1:0] hh_r;
  logic            neg_r;
  logic [63:0]     sum;
  logic [MW-1:0]   mag;
  q_t              p_r;

  assign ma = MW'(a_i[QW-1] ? -a_i : a_i);
  assign mb = MW'(b_i[QW-1] ? -b_i : b_i);

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r  <= 64'(ma[31:0]) * 64'(mb[31:0]);
      lh_r  <= MW'(MW'(ma[31:0]) * MW'(mb[MW-1:32]));
      hl_r  <= MW'(MW'(ma[MW-1:32]) * MW'(mb[31:0]));
      hh_r  <= (2*HW)'((2*HW)'(ma[MW-1:32]) * (2*HW)'(mb[MW-1:32]));
      neg_r <= a_i[QW-1] ^ b_i[QW-1];
    end
  end

  assign sum = (64'(hh_r) << 32) + 64'(lh_r) + 64'(hl_r) + 64'(ll_r[63:32])
             + 64'(ll_r[31]);
  assign mag = sum[MW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= neg_r ? -q_t'({1'b0, mag}) : q_t'({1'b0, mag});
    end
  end

  assign p_o = p_r;
endmodule

// ----- design/sct_qdiv.sv -----
// Three-stage rounded division of a signed Q32 value by a small constant.
// Depends on sct_pkg; uses a reciprocal product and one correction step.
module sct_qdiv import sct_pkg::*; #(
  parameter int unsigned K = 6
) (
  input  logic clk,
  input  logic en,
  input  q_t   a_i,
  output q_t   q_o
);
  localparam int unsigned HALF = K / 2;
  localparam logic [RECW-1:0] RECIP = RECW'((64'd1 << DIV_SHIFT) / K);
  localparam int FW = MW + RECW;
  localparam int EW = MW + KW;

  logic [MW-1:0]   m, n;
  logic [63:0]     ll_r;
  logic [RECW-1:0] lh_r;
  logic [MW-1:0]   hl_r;
  logic [10:0]     hh_r;
  logic [MW-1:0]   n1_r, n2_r, qe_r;
  logic            neg1_r, neg2_r;
  logic [FW-1:0]   full;
  logic [EW-1:0]   prodk, rem;
  logic [MW-1:0]   qv;
  q_t              q_r;

  assign m = MW'(a_i[QW-1] ? -a_i : a_i);
  assign n = m + MW'(HALF);

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r   <= 64'(n[31:0]) * 64'(RECIP[31:0]);
      lh_r   <= RECW'(RECW'(n[31:0]) * RECW'(RECIP[RECW-1:32]));
      hl_r   <= MW'(MW'(n[MW-1:32]) * MW'(RECIP[31:0]));
      hh_r   <= 11'(11'(n[MW-1:32]) * 11'(RECIP[RECW-1:32]));
      n1_r   <= n;
      neg1_r <= a_i[QW-1];
    end
  end

  assign full = (FW'(hh_r) << 64) + (FW'(lh_r) << 32) + (FW'(hl_r) << 32) + FW'(ll_r);

  always_ff @(posedge clk) begin
    if (en) begin
      qe_r   <= MW'(full >> DIV_SHIFT);
      n2_r   <= n1_r;
      neg2_r <= neg1_r;
    end
  end

  // The estimate is the true quotient or one below it.
  assign prodk = EW'(qe_r) * EW'(K);
  assign rem   = EW'(n2_r) - prodk;
  assign qv    = (rem >= EW'(K)) ? qe_r + MW'(1) : qe_r;

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= neg2_r ? -q_t'({1'b0, qv}) : q_t'({1'b0, qv});
    end
  end

  assign q_o = q_r;
endmodule

// ----- design/sct_sin_lane.sv -----
// Pipelined five-term Taylor sine of a reduced Q32 angle.
// Depends on sct_pkg, sct_qmul and sct_qdiv.
module sct_sin_lane import sct_pkg::*; (
  input  logic clk,
  input  logic en,
  input  q_t   x_i,
  output q_t   s_o
);
  q_t x2;
  q_t x_d_r [0:1];
  q_t term_s [0:NTERM];
  q_t x2_s   [0:NTERM];
  q_t res_s  [0:NTERM];

  sct_qmul u_square (.clk(clk), .en(en), .a_i(x_i), .b_i(x_i), .p_o(x2));

  always_ff @(posedge clk) begin
    if (en) begin
      x_d_r[0] <= x_i;
      x_d_r[1] <= x_d_r[0];
    end
  end

  assign term_s[0] = x_d_r[1];
  assign x2_s[0]   = x2;
  assign res_s[0]  = x_d_r[1];

  for (genvar j = 0; j < NTERM; j++) begin : g_term
    q_t prod, quo;
    q_t x2_l_r  [0:4];
    q_t res_l_r [0:4];
    q_t term_acc_r, x2_acc_r, res_acc_r;

    sct_qmul u_mul (.clk(clk), .en(en), .a_i(term_s[j]), .b_i(x2_s[j]), .p_o(prod));
    sct_qdiv #(.K(term_div(j))) u_div (.clk(clk), .en(en), .a_i(prod), .q_o(quo));

    always_ff @(posedge clk) begin
      if (en) begin
        x2_l_r[0]  <= x2_s[j];
        res_l_r[0] <= res_s[j];
        for (int i = 1; i < 5; i++) begin
          x2_l_r[i]  <= x2_l_r[i-1];
          res_l_r[i] <= res_l_r[i-1];
        end
        term_acc_r <= quo;
        x2_acc_r   <= x2_l_r[4];
        // Terms alternate in sign, starting with a subtraction.
        res_acc_r  <= (j % 2 == 0) ? res_l_r[4] - quo : res_l_r[4] + quo;
      end
    end

    assign term_s[j+1] = term_acc_r;
    assign x2_s[j+1]   = x2_acc_r;
    assign res_s[j+1]  = res_acc_r;
  end

  assign s_o = res_s[NTERM];
endmodule

// ----- design/sct_tan_div.sv -----
// Pipelined restoring divider for the tangent quotient floor(ms * 2^32 / mc).
// Depends on sct_pkg.
module sct_tan_div import sct_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [DM-1:0] ms_i,
  input  logic [DM-1:0] mc_i,
  output logic [QB-1:0] q_o
);
  localparam int RW = DM + 1;

  logic [RW-1:0] rem_r [0:NSTG];
  logic [QB-1:0] q_r   [0:NSTG];
  logic [DM-1:0] ms_r  [0:NSTG];
  logic [DM-1:0] mc_r  [0:NSTG];

  // The quotient stays below 2^QB, so the top of the dividend is already
  // below the divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= RW'(ms_i >> (QB - FRAC));
      q_r[0]   <= '0;
      ms_r[0]  <= ms_i;
      mc_r[0]  <= mc_i;
    end
  end

  for (genvar g = 0; g < NSTG; g++) begin : g_stage
    logic [DM+FRAC-1:0] dvd;
    logic [RW-1:0] rc [0:SPS];
    logic [QB-1:0] qc [0:SPS];

    assign dvd   = {ms_r[g], {FRAC{1'b0}}};
    assign rc[0] = rem_r[g];
    assign qc[0] = q_r[g];

    for (genvar s = 0; s < SPS; s++) begin : g_step
      localparam int T = g * SPS + s;
      if (T < QB) begin : g_live
        localparam int I = QB - 1 - T;
        logic [RW-1:0] sh;
        logic          ge;
        assign sh        = {rc[s][RW-2:0], dvd[I]};
        assign ge        = sh >= {1'b0, mc_r[g]};
        assign rc[s+1]   = ge ? sh - {1'b0, mc_r[g]} : sh;
        assign qc[s+1]   = {qc[s][QB-2:0], ge};
      end else begin : g_idle
        assign rc[s+1] = rc[s];
        assign qc[s+1] = qc[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g+1] <= rc[SPS];
        q_r[g+1]   <= qc[SPS];
        ms_r[g+1]  <= ms_r[g];
        mc_r[g+1]  <= mc_r[g];
      end
    end
  end

  assign q_o = q_r[NSTG];
endmodule

// ----- design/sine_cosine_tangent.sv -----
// Top level of the fixed-point sine, cosine and tangent pipeline.
// Depends on sct_pkg, sct_if, sct_sin_lane and sct_tan_div.
//
// Usage:
// A request on in_chan carries an action (0 sine, 1 cosine, 2 tangent) and
// an angle in radians with 27 fraction bits. Each request yields exactly one
// result on out_chan: a 48-bit value with 32 fraction bits and the
// small_cosine flag, which is set only when a tangent was forced to zero
// because the absolute cosine fell below 0.0001. Action 3 returns zero.
// Results leave in request order.
//
// The delay from acceptance to the result on out_chan is the same for every
// action. Throughput is one request per cycle while out_chan.ready does not
// hold the pipeline. The depth comes from the Taylor lanes (a pipelined
// multiplier and a constant divider per term) and the tangent divider, which
// resolves four quotient bits per stage.
//
// Reset clears all valid bits and holds in_chan.ready low; payload registers
// are not reset. When the receiver holds out_chan.ready low with a result
// waiting, the whole pipeline holds and in_chan.ready goes low; bubbles
// still move while the output stage is empty, so nothing is lost or repeated.
module sine_cosine_tangent import sct_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  sct_in_if.sink   in_chan,
  sct_out_if.source out_chan
);

  logic stage_en;
  logic vld_r [0:TOTAL_LAT-1];

  // The pipeline advances unless a finished result is stuck at the output.
  assign stage_en      = !vld_r[TOTAL_LAT-1] || out_chan.ready;
  assign in_chan.ready = stage_en && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOTAL_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (stage_en) begin
      vld_r[0] <= in_chan.valid;
      for (int i = 1; i < TOTAL_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // Folds an angle into [0, 2*pi); the input never spans more than three
  // periods on either side of zero.
  function automatic q_t wrap_two_pi(q_t a);
    q_t r, c;
    r = '0;
    for (int k = -3; k <= 3; k++) begin
      c = a + q_t'(k) * Q_TWO_PI;
      if (c >= 0 && c < Q_TWO_PI) begin
        r = c;
      end
    end
    return r;
  endfunction

  // Stage 0: scale the angle to 32 fraction bits and form both lane inputs.
  // Lane A carries the sine or cosine argument, lane B always the cosine one.
  logic [1:0] act0_r, act1_r, act2_r;
  q_t         va_r, vb_r, wa_r, wb_r, xa_r, xb_r;
  q_t         v_in;

  assign v_in = {{3{in_chan.angle[31]}}, in_chan.angle, 5'b0};

  always_ff @(posedge clk) begin
    if (stage_en) begin
      act0_r <= in_chan.action;
      va_r   <= (in_chan.action == ACT_COS) ? v_in + Q_HALF_PI : v_in;
      vb_r   <= v_in + Q_HALF_PI;
      // Stage 1: reduce modulo 2*pi.
      act1_r <= act0_r;
      wa_r   <= wrap_two_pi(va_r);
      wb_r   <= wrap_two_pi(vb_r);
      // Stage 2: move the upper half of the period below zero.
      act2_r <= act1_r;
      xa_r   <= (wa_r > Q_PI) ? wa_r - Q_TWO_PI : wa_r;
      xb_r   <= (wb_r > Q_PI) ? wb_r - Q_TWO_PI : wb_r;
    end
  end

  q_t sin_a, sin_b;

  sct_sin_lane u_lane_a (.clk(clk), .en(stage_en), .x_i(xa_r), .s_o(sin_a));
  sct_sin_lane u_lane_b (.clk(clk), .en(stage_en), .x_i(xb_r), .s_o(sin_b));

  logic [1:0] act_l_r [0:LANE_LAT-1];

  always_ff @(posedge clk) begin
    if (stage_en) begin
      act_l_r[0] <= act2_r;
      for (int i = 1; i < LANE_LAT; i++) begin
        act_l_r[i] <= act_l_r[i-1];
      end
    end
  end

  // Tangent setup: magnitudes, sign and the near-zero cosine test.
  q_t            s_mag, c_mag;
  side_t         side_t_r;
  logic [DM-1:0] ms_r, mc_r;

  assign s_mag = sin_a[QW-1] ? -sin_a : sin_a;
  assign c_mag = sin_b[QW-1] ? -sin_b : sin_b;

  always_ff @(posedge clk) begin
    if (stage_en) begin
      side_t_r.act      <= act_l_r[LANE_LAT-1];
      side_t_r.cos_tiny <= c_mag < Q_TAN_EPS;
      side_t_r.neg      <= sin_a[QW-1] ^ sin_b[QW-1];
      side_t_r.pass     <= sin_a;
      ms_r              <= s_mag[DM-1:0];
      mc_r              <= c_mag[DM-1:0];
    end
  end

  logic [QB-1:0] quo;
  side_t         side_d_r [0:DIV_LAT-1];

  sct_tan_div u_tan_div (.clk(clk), .en(stage_en), .ms_i(ms_r), .mc_i(mc_r), .q_o(quo));

  always_ff @(posedge clk) begin
    if (stage_en) begin
      side_d_r[0] <= side_t_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        side_d_r[i] <= side_d_r[i-1];
      end
    end
  end

  // Output stage. The quotient and the polynomial both stay well inside the
  // 48-bit range, so sign extension is the whole of the saturation.
  side_t              side_f;
  logic signed [47:0] value_nxt;
  logic               small_nxt;
  logic signed [47:0] value_r;
  logic               small_r;

  assign side_f = side_d_r[DIV_LAT-1];

  always_comb begin
    value_nxt = '0;
    small_nxt = 1'b0;
    case (side_f.act)
      ACT_SIN, ACT_COS: begin
        value_nxt = 48'(side_f.pass);
      end
      ACT_TAN: begin
        if (side_f.cos_tiny) begin
          small_nxt = 1'b1;
        end else begin
          value_nxt = side_f.neg ? -48'({1'b0, quo}) : 48'({1'b0, quo});
        end
      end
      default: begin
        value_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stage_en) begin
      value_r <= value_nxt;
      small_r <= small_nxt;
    end
  end

  assign out_chan.valid        = vld_r[TOTAL_LAT-1];
  assign out_chan.value        = value_r;
  assign out_chan.small_cosine = small_r;

`ifndef SYNTHESIS
  // A held pipeline keeps the first and last valid bits in place.
  a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !stage_en |=> vld_r[0] == $past(vld_r[0]) && vld_r[TOTAL_LAT-1]
                  == $past(vld_r[TOTAL_LAT-1]))
    else $error("pipeline moved while held");

  // An accepted request always occupies the first stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> vld_r[0])
    else $error("accepted request was dropped");

  // A flagged tangent always comes back as zero.
  a_small_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.small_cosine |-> out_chan.value == 48'sd0)
    else $error("small cosine flag with nonzero value");
`endif

endmodule
